/* design/qvr_pkg.sv */
// Shared types and constants for the quaternion vector rotator.
package qvr_pkg;

  localparam int QUAT_W       = 16;
  localparam int VEC_IN_W     = 16;
  localparam int PROD_W       = QUAT_W + VEC_IN_W;
  localparam int T_W          = PROD_W + 2;
  localparam int RPROD_W      = QUAT_W + T_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF      = 16;

  typedef logic signed [QUAT_W-1:0]   qvr_quat_t;
  typedef logic signed [VEC_IN_W-1:0] qvr_vec_t;
  typedef logic signed [PROD_W-1:0]   qvr_prod_t;
  typedef logic signed [T_W-1:0]      qvr_tsum_t;
  typedef logic signed [RPROD_W-1:0]  qvr_rprod_t;

  // Quaternion plus intermediate t = (0,v) * conj(q)
  typedef struct packed {
    qvr_quat_t w;
    qvr_quat_t x;
    qvr_quat_t y;
    qvr_quat_t z;
    qvr_tsum_t t0;
    qvr_tsum_t t1;
    qvr_tsum_t t2;
    qvr_tsum_t t3;
  } qvr_mid_t;

endpackage

/* design/quaternion_vector_rotator_top.sv */
// Quaternion vector rotator: rotates v by q as q * (0,v) * conj(q).
//
// Input channel: in_valid/in_ready carry a Q2.14 quaternion (in_quat_*) and a
// signed integer vector (in_vec_*); a transfer happens when both are high.
// Result channel: out_valid/out_ready carry the rotated vector (out_rot_*),
// rounded half up and saturated to VEC_WIDTH+1 bits, and out_clipped, set
// when any component saturated.
// Throughput: one transfer per cycle on each side while out_ready is held
// high, set by fully pipelined multipliers (twelve 16x16 in the front,
// twelve 16x34 in the back). Between input transfer and out_valid lie two
// front stages, one queue stage and three back stages (the last is the
// output register).
// A stalled receiver holds the output register; the pipeline and the
// two-entry queue between front and back keep accepting until full, then
// in_ready drops. No state is kept between items.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
module quaternion_vector_rotator_top
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = VEC_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        in_quat_w,
  input  logic signed [15:0]        in_quat_x,
  input  logic signed [15:0]        in_quat_y,
  input  logic signed [15:0]        in_quat_z,
  input  logic signed [15:0]        in_vec_x,
  input  logic signed [15:0]        in_vec_y,
  input  logic signed [15:0]        in_vec_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VEC_WIDTH:0] out_rot_x,
  output logic signed [VEC_WIDTH:0] out_rot_y,
  output logic signed [VEC_WIDTH:0] out_rot_z,
  output logic                      out_clipped
);

  logic     f_valid, f_ready;
  qvr_mid_t f_data;
  logic     q_valid, q_ready;
  qvr_mid_t q_data;

  qvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_quat_w (in_quat_w),
    .in_quat_x (in_quat_x),
    .in_quat_y (in_quat_y),
    .in_quat_z (in_quat_z),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_vec_z  (in_vec_z),
    .mid_valid (f_valid),
    .mid_ready (f_ready),
    .mid_data  (f_data)
  );

  qvr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  qvr_back #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_WIDTH      (VEC_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mid_valid   (q_valid),
    .mid_ready   (q_ready),
    .mid_data    (q_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rot_x   (out_rot_x),
    .out_rot_y   (out_rot_y),
    .out_rot_z   (out_rot_z),
    .out_clipped (out_clipped)
  );

endmodule

/* design/qvr_front.sv */
// Front end: accepts items and forms t = (0,v) * conj(q) in two stages.
module qvr_front
  import qvr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  qvr_quat_t in_quat_w,
  input  qvr_quat_t in_quat_x,
  input  qvr_quat_t in_quat_y,
  input  qvr_quat_t in_quat_z,
  input  qvr_vec_t  in_vec_x,
  input  qvr_vec_t  in_vec_y,
  input  qvr_vec_t  in_vec_z,
  output logic      mid_valid,
  input  logic      mid_ready,
  output qvr_mid_t  mid_data
);

  logic      v1_r, v2_r;
  logic      adv1, adv2;
  qvr_prod_t p_r   [12];
  qvr_prod_t p_nxt [12];
  qvr_quat_t w1_r, x1_r, y1_r, z1_r;
  qvr_mid_t  mid_r, mid_nxt;

  assign adv2      = !v2_r || mid_ready;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign mid_valid = v2_r;
  assign mid_data  = mid_r;

  always_comb begin
    p_nxt[0]  = in_vec_x * in_quat_x;
    p_nxt[1]  = in_vec_y * in_quat_y;
    p_nxt[2]  = in_vec_z * in_quat_z;
    p_nxt[3]  = in_vec_x * in_quat_w;
    p_nxt[4]  = in_vec_y * in_quat_z;
    p_nxt[5]  = in_vec_z * in_quat_y;
    p_nxt[6]  = in_vec_x * in_quat_z;
    p_nxt[7]  = in_vec_y * in_quat_w;
    p_nxt[8]  = in_vec_z * in_quat_x;
    p_nxt[9]  = in_vec_y * in_quat_x;
    p_nxt[10] = in_vec_x * in_quat_y;
    p_nxt[11] = in_vec_z * in_quat_w;
  end

  always_comb begin
    mid_nxt.w  = w1_r;
    mid_nxt.x  = x1_r;
    mid_nxt.y  = y1_r;
    mid_nxt.z  = z1_r;
    mid_nxt.t0 = T_W'(p_r[0]) + T_W'(p_r[1]) + T_W'(p_r[2]);
    mid_nxt.t1 = T_W'(p_r[3]) - T_W'(p_r[4]) + T_W'(p_r[5]);
    mid_nxt.t2 = T_W'(p_r[6]) + T_W'(p_r[7]) - T_W'(p_r[8]);
    mid_nxt.t3 = T_W'(p_r[9]) - T_W'(p_r[10]) + T_W'(p_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      p_r  <= p_nxt;
      w1_r <= in_quat_w;
      x1_r <= in_quat_x;
      y1_r <= in_quat_y;
      z1_r <= in_quat_z;
    end
    if (adv2 && v1_r) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

/* design/qvr_queue.sv */
// Short queue between front and back ends.
module qvr_queue
  import qvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  qvr_mid_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output qvr_mid_t rd_data
);

  qvr_mid_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign rd_valid = (count_r != QCNT_W'(0));
  assign pop      = rd_valid && rd_ready;
  assign wr_ready = (count_r != QCNT_W'(QUEUE_DEPTH)) || pop;
  assign push     = wr_valid && wr_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

/* design/qvr_back.sv */
// Back end: forms r = q * t, rounds, saturates and holds the result.
module qvr_back
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = VEC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_valid,
  output logic                  mid_ready,
  input  qvr_mid_t              mid_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [VEC_WIDTH:0] out_rot_x,
  output logic signed [VEC_WIDTH:0] out_rot_y,
  output logic signed [VEC_WIDTH:0] out_rot_z,
  output logic                  out_clipped
);

  localparam int S      = 2 * QUAT_FRAC_BITS;
  localparam int OUT_W  = VEC_WIDTH + 1;
  localparam int SUM_A  = RPROD_W + 2;
  localparam int SUM_B  = S + OUT_W + 1;
  localparam int SUM_W  = (SUM_A > SUM_B) ? SUM_A : SUM_B;
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (S - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << VEC_WIDTH) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << VEC_WIDTH);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [OUT_W-1:0] rot_t;

  logic       v1_r, v2_r, v3_r;
  logic       adv1, adv2, adv3;
  qvr_rprod_t m_r   [12];
  qvr_rprod_t m_nxt [12];
  sum_t       s_r   [3];
  sum_t       s_nxt [3];
  rot_t       rot_r [3];
  rot_t       rot_nxt [3];
  logic       clip_r, clip_nxt;
  sum_t       shv   [3];

  assign adv3      = !v3_r || out_ready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign mid_ready = adv1;
  assign out_valid = v3_r;
  assign out_rot_x = rot_r[0];
  assign out_rot_y = rot_r[1];
  assign out_rot_z = rot_r[2];
  assign out_clipped = clip_r;

  always_comb begin
    m_nxt[0]  = mid_data.x * mid_data.t0;
    m_nxt[1]  = mid_data.w * mid_data.t1;
    m_nxt[2]  = mid_data.y * mid_data.t3;
    m_nxt[3]  = mid_data.z * mid_data.t2;
    m_nxt[4]  = mid_data.w * mid_data.t2;
    m_nxt[5]  = mid_data.x * mid_data.t3;
    m_nxt[6]  = mid_data.y * mid_data.t0;
    m_nxt[7]  = mid_data.z * mid_data.t1;
    m_nxt[8]  = mid_data.w * mid_data.t3;
    m_nxt[9]  = mid_data.x * mid_data.t2;
    m_nxt[10] = mid_data.y * mid_data.t1;
    m_nxt[11] = mid_data.z * mid_data.t0;
  end

  always_comb begin
    s_nxt[0] = SUM_W'(m_r[0]) + SUM_W'(m_r[1]) + SUM_W'(m_r[2]) - SUM_W'(m_r[3]);
    s_nxt[1] = SUM_W'(m_r[4]) - SUM_W'(m_r[5]) + SUM_W'(m_r[6]) + SUM_W'(m_r[7]);
    s_nxt[2] = SUM_W'(m_r[8]) + SUM_W'(m_r[9]) - SUM_W'(m_r[10]) + SUM_W'(m_r[11]);
  end

  // round half up, then clamp
  always_comb begin
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      shv[i] = (s_r[i] + HALF) >>> S;
      if (shv[i] > SAT_HI) begin
        rot_nxt[i] = SAT_HI[OUT_W-1:0];
        clip_nxt   = 1'b1;
      end else if (shv[i] < SAT_LO) begin
        rot_nxt[i] = SAT_LO[OUT_W-1:0];
        clip_nxt   = 1'b1;
      end else begin
        rot_nxt[i] = shv[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= mid_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && mid_valid) m_r <= m_nxt;
    if (adv2 && v1_r)      s_r <= s_nxt;
    if (adv3 && v2_r) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

endmodule

/* dv/quaternion_vector_rotator_top_tb.sv */
// Self-checking testbench for the quaternion vector rotator, with a scoreboard and random stalls.
`timescale 1ns / 1ps

module quaternion_vector_rotator_top_tb
  import qvr_pkg::*;
();

  localparam int ROT_W       = VEC_WIDTH_DEF + 1;
  localparam int ROUND_SHIFT = 2 * QUAT_FRAC_BITS_DEF;

  localparam int N_RANDOM    = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef logic signed [ROT_W-1:0] rot_comp_t;

  typedef struct {
    qvr_quat_t w;
    qvr_quat_t x;
    qvr_quat_t y;
    qvr_quat_t z;
    qvr_vec_t  vx;
    qvr_vec_t  vy;
    qvr_vec_t  vz;
  } rot_req_t;

  typedef struct {
    rot_comp_t x;
    rot_comp_t y;
    rot_comp_t z;
    logic      clip;
  } rot_res_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum {GEN_FULL, GEN_NEAR_UNIT, GEN_TINY_VEC, GEN_AXIS, GEN_CORNERS} gen_kind_t;

  class rotation_scoreboard;
    rot_res_t rotated_q[$];
    int n_inputs;
    int n_checked;
    int n_clipped;
    int n_mismatch;
    int n_unexpected;
    int n_reported;

    function rot_comp_t round_saturate(longint acc, inout logic clip);
      longint hi;
      longint lo;
      longint r;
      hi = (longint'(1) <<< VEC_WIDTH_DEF) - 1;
      lo = -(longint'(1) <<< VEC_WIDTH_DEF);
      r  = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (r > hi) begin
        r = hi;
        clip = 1'b1;
      end else if (r < lo) begin
        r = lo;
        clip = 1'b1;
      end
      return rot_comp_t'(r);
    endfunction

    // q * (0,v) * conj(q), exact integers then round half up
    function rot_res_t rotate_vector(rot_req_t q);
      longint w, x, y, z, vx, vy, vz;
      longint t0, t1, t2, t3, r1, r2, r3;
      rot_res_t res;
      w  = q.w;
      x  = q.x;
      y  = q.y;
      z  = q.z;
      vx = q.vx;
      vy = q.vy;
      vz = q.vz;
      t0 = vx * x + vy * y + vz * z;
      t1 = vx * w - vy * z + vz * y;
      t2 = vx * z + vy * w - vz * x;
      t3 = vy * x - vx * y + vz * w;
      r1 = x * t0 + w * t1 + y * t3 - z * t2;
      r2 = w * t2 - x * t3 + y * t0 + z * t1;
      r3 = w * t3 + x * t2 - y * t1 + z * t0;
      res.clip = 1'b0;
      res.x = round_saturate(r1, res.clip);
      res.y = round_saturate(r2, res.clip);
      res.z = round_saturate(r3, res.clip);
      return res;
    endfunction

    function void note_input(rot_req_t q);
      rot_res_t res;
      res = rotate_vector(q);
      rotated_q.push_back(res);
      n_inputs++;
      if (res.clip) n_clipped++;
    endfunction

    function void check_result(rot_comp_t gx, rot_comp_t gy, rot_comp_t gz, logic gclip);
      rot_res_t e;
      if (rotated_q.size() == 0) begin
        n_unexpected++;
        if (n_reported < 10) begin
          $display("unexpected result: rot=(%0d,%0d,%0d) clipped=%b", gx, gy, gz, gclip);
          n_reported++;
        end
        return;
      end
      e = rotated_q.pop_front();
      n_checked++;
      if (gx !== e.x || gy !== e.y || gz !== e.z || gclip !== e.clip) begin
        n_mismatch++;
        if (n_reported < 10) begin
          $display("mismatch on result %0d: expected (%0d,%0d,%0d) clipped=%b,",
                   n_checked, e.x, e.y, e.z, e.clip);
          $display("  got (%0d,%0d,%0d) clipped=%b", gx, gy, gz, gclip);
          n_reported++;
        end
      end
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  qvr_quat_t in_quat_w;
  qvr_quat_t in_quat_x;
  qvr_quat_t in_quat_y;
  qvr_quat_t in_quat_z;
  qvr_vec_t  in_vec_x;
  qvr_vec_t  in_vec_y;
  qvr_vec_t  in_vec_z;
  logic      out_valid;
  logic      out_ready;
  rot_comp_t out_rot_x;
  rot_comp_t out_rot_y;
  rot_comp_t out_rot_z;
  logic      out_clipped;

  rotation_scoreboard sb = new();
  int  cycle_cnt = 0;
  bit  hold_request = 1'b0;
  int  n_directed = 0;

  quaternion_vector_rotator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rot_x  (out_rot_x),
    .out_rot_y  (out_rot_y),
    .out_rot_z  (out_rot_z),
    .out_clipped(out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // both channels are stable mid-cycle; a transfer seen here lands on the next rising edge
  always @(negedge clk) begin
    rot_req_t q;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        q.w  = in_quat_w;
        q.x  = in_quat_x;
        q.y  = in_quat_y;
        q.z  = in_quat_z;
        q.vx = in_vec_x;
        q.vy = in_vec_y;
        q.vz = in_vec_z;
        sb.note_input(q);
      end
      if (out_valid && out_ready) sb.check_result(out_rot_x, out_rot_y, out_rot_z, out_clipped);
    end
  end

  function automatic rot_req_t mk_req(int w, int x, int y, int z, int vx, int vy, int vz);
    rot_req_t q;
    q.w  = qvr_quat_t'(w);
    q.x  = qvr_quat_t'(x);
    q.y  = qvr_quat_t'(y);
    q.z  = qvr_quat_t'(z);
    q.vx = qvr_vec_t'(vx);
    q.vy = qvr_vec_t'(vy);
    q.vz = qvr_vec_t'(vz);
    return q;
  endfunction

  function automatic int rand16();
    return int'(qvr_quat_t'($urandom_range(0, 16'hFFFF)));
  endfunction

  function automatic int near_unit();
    return int'($urandom_range(0, 18000)) - 9000;
  endfunction

  function automatic int pick_corner();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return -32768;
      2: return 32767;
      default: return rand16();
    endcase
  endfunction

  function automatic int axis_value();
    case ($urandom_range(0, 4))
      0: return 16384;
      1: return -16384;
      2: return 11585;
      3: return -11585;
      default: return 0;
    endcase
  endfunction

  function automatic rot_req_t make_random_req();
    gen_kind_t kind;
    int s;
    s = $urandom_range(0, 9);
    if (s < 3)      kind = GEN_FULL;
    else if (s < 6) kind = GEN_NEAR_UNIT;
    else if (s < 7) kind = GEN_TINY_VEC;
    else if (s < 9) kind = GEN_AXIS;
    else            kind = GEN_CORNERS;
    case (kind)
      GEN_FULL:
        return mk_req(rand16(), rand16(), rand16(), rand16(), rand16(), rand16(), rand16());
      GEN_NEAR_UNIT:
        return mk_req(near_unit(), near_unit(), near_unit(), near_unit(),
                      rand16(), rand16(), rand16());
      GEN_TINY_VEC:
        return mk_req(near_unit(), near_unit(), near_unit(), near_unit(),
                      int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
                      int'($urandom_range(0, 16)) - 8);
      GEN_AXIS:
        return mk_req(axis_value(), axis_value(), axis_value(), axis_value(),
                      rand16(), rand16(), rand16());
      default:
        return mk_req(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                      pick_corner(), pick_corner(), pick_corner());
    endcase
  endfunction

  task automatic send_req(input rot_req_t q);
    logic took;
    in_valid  <= 1'b1;
    in_quat_w <= q.w;
    in_quat_x <= q.x;
    in_quat_y <= q.y;
    in_quat_z <= q.z;
    in_vec_x  <= q.vx;
    in_vec_y  <= q.vy;
    in_vec_z  <= q.vz;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: one long hold on request, otherwise random stall segments
  initial begin
    rx_mode_t mode;
    int len;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        for (int i = 0; i < LONG_HOLD; i++) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
        hold_request = 1'b0;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (i % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    rot_req_t directed_q[$];
    int n_random;
    int burst;
    int errors;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_vec_x  = '0;
    in_vec_y  = '0;
    in_vec_z  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, axis turns, non-unit scale, half-up ties, saturation both ways
    directed_q.push_back(mk_req(16384, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_req(16384, 0, 0, 0, 32767, -32768, 1));
    directed_q.push_back(mk_req(16384, 0, 0, 0, -32768, 32767, -1));
    directed_q.push_back(mk_req(11585, 0, 0, 11585, 1000, 0, 0));
    directed_q.push_back(mk_req(11585, 11585, 0, 0, 0, 1000, -500));
    directed_q.push_back(mk_req(11585, 0, -11585, 0, 300, 200, 100));
    directed_q.push_back(mk_req(0, 16384, 0, 0, 32767, 32767, 32767));
    directed_q.push_back(mk_req(-16384, 0, 0, 0, -32768, -32768, -32768));
    directed_q.push_back(mk_req(32767, 0, 0, 0, 100, -100, 7));
    directed_q.push_back(mk_req(4096, 0, 0, 0, 1000, -1000, 17));
    directed_q.push_back(mk_req(8192, 0, 0, 0, 2, -2, 6));
    directed_q.push_back(mk_req(8192, 0, 0, 0, -6, 1, -1));
    directed_q.push_back(mk_req(-32768, 0, 0, 0, 32767, 0, 0));
    directed_q.push_back(mk_req(-32768, 0, 0, 0, -32768, -32768, -32768));
    directed_q.push_back(mk_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    directed_q.push_back(mk_req(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    directed_q.push_back(mk_req(0, 0, 0, 0, -32768, 32767, -32768));
    directed_q.push_back(mk_req(0, 0, 0, -32768, 1, 2, 3));
    directed_q.push_back(mk_req(16384, 16384, 16384, 16384, 16000, -16000, 0));
    directed_q.push_back(mk_req(23170, 0, 0, 0, 32767, 0, 0));
    directed_q.push_back(mk_req(21845, -21846, 21845, -21846, 21845, -21846, 21845));
    directed_q.push_back(mk_req(-21846, 21845, -21846, 21845, -21846, 21845, -21846));
    foreach (directed_q[i]) send_req(directed_q[i]);
    n_directed = directed_q.size();
    idle_sender(3);

    // fill the pipeline while the receiver holds off
    hold_request = 1'b1;
    n_random = 0;
    repeat (40) begin
      send_req(make_random_req());
      n_random++;
    end

    while (n_random < N_RANDOM) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && n_random < N_RANDOM; i++) begin
        send_req(make_random_req());
        n_random++;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    errors = sb.n_mismatch + sb.n_unexpected + sb.pending();
    $display("Rotated %0d vectors (%0d directed, %0d random), %0d results checked, %0d saturated.",
             sb.n_inputs, n_directed, n_random, sb.n_checked, sb.n_clipped);
    $display("Mismatches %0d, unexpected results %0d, missing results %0d.",
             sb.n_mismatch, sb.n_unexpected, sb.pending());
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
